// ----- sv/sst_pkg.sv -----
`timescale 1ns / 1ps

package sst_pkg;

    // Command codes carried by an input transfer.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } t_cell_ctl;

endpackage

// ----- sv/sst_cell.sv -----
`timescale 1ns / 1ps

module sst_cell (
    input  logic                                i_clk,
    input  sst_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [sst_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_occupied,
    input  logic signed [sst_pkg::VALUE_W-1:0]  i_left_value,
    input  logic                                i_left_lt,
    input  logic signed [sst_pkg::VALUE_W-1:0]  i_right_value,
    output logic signed [sst_pkg::VALUE_W-1:0]  o_value,
    output logic                                o_lt,
    output logic                                o_eq
);

    logic signed [sst_pkg::VALUE_W-1:0] r_entry;
    logic                               r_lt;
    logic                               r_eq;

    // An unoccupied cell never counts as less, so the first free cell
    // sits at or beyond the insertion point.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= i_occupied && (r_entry < i_value);
            r_eq <= i_occupied && (r_entry == i_value);
        end
    end

    // Cells left of the insertion point keep their entry. The cell at the
    // point takes the new value; cells beyond it take their left neighbor.
    // On a remove every cell from the match onward takes its right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en && !r_lt) begin
            r_entry <= i_left_lt ? i_value : i_left_value;
        end else if (i_ctl.rem_en && !r_lt) begin
            r_entry <= i_right_value;
        end
    end

    assign o_value = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// ----- sv/sst_ctrl.sv -----
`timescale 1ns / 1ps

module sst_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic signed [sst_pkg::VALUE_W-1:0]  i_value,
    output logic signed [sst_pkg::VALUE_W-1:0]  o_value,
    output sst_pkg::t_cell_ctl                  o_ctl,
    input  logic                                i_present,
    output logic [CNT_W-1:0]                    o_entry_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_success,
    output logic [CNT_W-1:0]                    o_count,
    output logic                                o_is_empty
);

    sst_pkg::t_state                    r_state;
    sst_pkg::t_state                    n_state;
    logic [1:0]                         r_cmd;
    logic signed [sst_pkg::VALUE_W-1:0] r_val;
    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    logic                               r_out_valid;
    logic                               r_success;
    logic                               n_success;
    logic [CNT_W-1:0]                   r_out_count;
    logic                               r_is_empty;
    logic                               commit;
    logic                               accept;
    logic                               ins_ok;
    logic                               rem_ok;

    // A result is committed once the output register is free or drains now.
    assign commit = (r_state == sst_pkg::ST_UPD) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == sst_pkg::ST_IDLE) || commit);
    assign accept = i_in_valid && !o_in_stall;

    assign ins_ok = (r_cmd == sst_pkg::CMD_INSERT) && !i_present
                    && (r_count < CNT_W'(CAPACITY));
    assign rem_ok = (r_cmd == sst_pkg::CMD_REMOVE) && i_present;

    always_comb begin
        n_count   = r_count;
        n_success = 1'b0;
        if (ins_ok) begin
            n_count   = r_count + CNT_W'(1);
            n_success = 1'b1;
        end else if (rem_ok) begin
            n_count   = r_count - CNT_W'(1);
            n_success = 1'b1;
        end else if (r_cmd == sst_pkg::CMD_SEARCH) begin
            n_success = i_present;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sst_pkg::ST_IDLE: begin
                if (accept) n_state = sst_pkg::ST_CMP;
            end
            sst_pkg::ST_CMP: begin
                n_state = sst_pkg::ST_UPD;
            end
            sst_pkg::ST_UPD: begin
                if (commit) n_state = accept ? sst_pkg::ST_CMP : sst_pkg::ST_IDLE;
            end
            default: begin
                n_state = sst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl.cmp_en = (r_state == sst_pkg::ST_CMP);
        o_ctl.ins_en = commit && ins_ok;
        o_ctl.rem_en = commit && rem_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sst_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_val <= i_value;
        end
        if (commit) begin
            r_success   <= n_success;
            r_out_count <= n_count;
            r_is_empty  <= (n_count == '0);
        end
    end

    assign o_value       = r_val;
    assign o_entry_count = r_count;
    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_count       = r_out_count;
    assign o_is_empty    = r_is_empty;

endmodule

// ----- sv/sorted_set_table.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     i_in_valid / o_in_stall     i_cmd[1:0], i_value[31:0] signed
// output    o_out_valid / i_out_stall   o_success, o_count, o_is_empty
//
// Each transfer: a compare state checks the value against every cell of
// the chain at once; the update state shifts it and registers the result.
// A new input is taken in the cycle the previous result is committed.
// Synchronous active-low reset empties the table; cell contents are not reset.
// While the output register is held by i_out_stall, commit and input wait.

module sorted_set_table #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic signed [sst_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_success,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count,
    output logic                                o_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    sst_pkg::t_cell_ctl                 ctl;
    logic signed [sst_pkg::VALUE_W-1:0] op_value;
    logic [CNT_W-1:0]                   entry_count;
    logic signed [sst_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]                cell_lt;
    logic [CAPACITY-1:0]                cell_eq;

    sst_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_value       (op_value),
        .o_ctl         (ctl),
        .i_present     (|cell_eq),
        .o_entry_count (entry_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_success     (o_success),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [sst_pkg::VALUE_W-1:0] left_value;
        logic                               left_lt;
        logic signed [sst_pkg::VALUE_W-1:0] right_value;

        // The head cell sees a virtual neighbor that is always less, so an
        // insert before every entry lands in it.
        if (g == 0) begin : g_head
            assign left_value = cell_value[g];
            assign left_lt    = 1'b1;
        end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        sst_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_value       (op_value),
            .i_occupied    (entry_count > CNT_W'(g)),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

endmodule
